@@ sv/ffba_pkg.sv @@
package ffba_pkg;

  // Field widths fixed by the request and response formats
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SPACE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'd1;

  // Configuration reset values
  localparam logic [DATA_W-1:0] HEAP_BASE_RST  = 32'd0;
  localparam logic [DATA_W-1:0] HEAP_LIMIT_RST = 32'd65536;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] release_address;
  } ffba_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   payload_address;
    logic [STATUS_W-1:0] status;
  } ffba_rsp_t;

endpackage

@@ sv/ffba_ram.sv @@
module ffba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ffba_cmp_unit.sv @@
module ffba_cmp_unit import ffba_pkg::*; #(
  parameter int unsigned ADDR_WIDTH   = 32,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic                  op_i,
  input  logic [ADDR_WIDTH-1:0] start_i,
  input  logic [DATA_W-1:0]     bytes_i,
  input  logic                  free_i,
  input  logic [DATA_W-1:0]     size_i,
  input  logic [DATA_W-1:0]     addr_i,
  output logic [ADDR_WIDTH-1:0] payload_o,
  output logic                  hit_o
);

  // Compare width covers both the address space and the 32-bit request
  localparam int unsigned CW = (ADDR_WIDTH > DATA_W) ? ADDR_WIDTH : DATA_W;

  logic [CW-1:0] pay_ext;
  logic [CW-1:0] addr_ext;
  logic [CW-1:0] addr_msk;

  // Payload address sits past the block header, wrapping in the address space
  assign payload_o = start_i + ADDR_WIDTH'(HEADER_BYTES);

  assign pay_ext  = CW'(payload_o);
  assign addr_ext = CW'(addr_i);
  assign addr_msk = CW'(ADDR_WIDTH'(addr_ext));

  // Allocate: free block large enough; free: payload address matches
  always_comb begin
    if (op_i == OP_ALLOC) begin
      hit_o = free_i && (bytes_i >= size_i);
    end else begin
      hit_o = (pay_ext == addr_msk);
    end
  end

endmodule

@@ sv/first_fit_block_allocator_unit.sv @@
// First-fit block allocator. Each request beat is an allocate or a free and
// yields exactly one response beat. An allocate walks the block table in
// creation order, one entry per cycle through a single compare unit, and
// reuses the first free block that is large enough; failing that it appends
// a block at the heap break if the table and heap_limit allow. A free walks
// the same table for the matching payload address. The table walk runs through
// the registered table RAMs, so the time a request takes grows with the number
// of entries it visits; zero-size allocates and frees of address zero skip the
// walk. The unit takes one request at a time.
// Configuration writes are always accepted and must only be issued while idle.
module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned ADDR_WIDTH   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ffba_req_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ffba_rsp_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned NW   = DATA_W + 2;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_APPEND = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0]            state_q, state_d;
  ffba_req_t             req_q, req_d;
  ffba_rsp_t             res_q, res_d;
  ffba_rsp_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic [CNTW-1:0]       count_q, count_d;
  logic [DATA_W-1:0]     used_q, used_d;
  logic [DATA_W-1:0]     base_q, limit_q;
  logic [CNTW-1:0]       rd_idx_q, rd_idx_d;
  logic                  cmp_v_q, cmp_v_d;
  logic [IW-1:0]         cmp_idx_q, cmp_idx_d;

  logic [ADDR_WIDTH-1:0] start_rd;
  logic [DATA_W-1:0]     bytes_rd;
  logic                  free_rd;
  logic [ADDR_WIDTH-1:0] new_start;
  logic [ADDR_WIDTH-1:0] cmp_start;
  logic [ADDR_WIDTH-1:0] cmp_payload;
  logic                  cmp_hit;
  logic [NW-1:0]         need;
  logic                  scan_last;

  logic                  tbl_we;
  logic                  flag_we;
  logic                  flag_wdata;
  logic [IW-1:0]         wr_addr;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Heap break for a new block and the bytes consumed if it is appended
  assign new_start = ADDR_WIDTH'({1'b0, base_q} + {1'b0, used_q});
  assign need      = NW'(used_q) + NW'(HEADER_BYTES) + NW'(req_q.request_size);
  assign scan_last = ((CNTW'(cmp_idx_q) + CNTW'(1)) == count_q);

  // Table storage
  ffba_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(MAX_BLOCKS)) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (wr_addr),
    .wdata_i (new_start),
    .raddr_i (rd_idx_q[IW-1:0]),
    .rdata_o (start_rd)
  );

  ffba_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BLOCKS)) u_bytes_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (wr_addr),
    .wdata_i (req_q.request_size),
    .raddr_i (rd_idx_q[IW-1:0]),
    .rdata_o (bytes_rd)
  );

  ffba_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (wr_addr),
    .wdata_i (flag_wdata),
    .raddr_i (rd_idx_q[IW-1:0]),
    .rdata_o (free_rd)
  );

  // Shared adder and comparator: table entries while scanning, new block on append
  assign cmp_start = (state_q == S_APPEND) ? new_start : start_rd;

  ffba_cmp_unit #(.ADDR_WIDTH(ADDR_WIDTH), .HEADER_BYTES(HEADER_BYTES)) u_cmp (
    .op_i      (req_q.opcode),
    .start_i   (cmp_start),
    .bytes_i   (bytes_rd),
    .free_i    (free_rd),
    .size_i    (req_q.request_size),
    .addr_i    (req_q.release_address),
    .payload_o (cmp_payload),
    .hit_o     (cmp_hit)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    count_d     = count_q;
    used_d      = used_q;
    rd_idx_d    = rd_idx_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    tbl_we      = 1'b0;
    flag_we     = 1'b0;
    flag_wdata  = 1'b0;
    wr_addr     = cmp_idx_q;

    case (state_q)
      S_IDLE: begin
        rd_idx_d = '0;
        if (in_valid_i) begin
          req_d                 = in_data_i;
          res_d.payload_address = '0;
          res_d.status          = ST_OK;
          if (in_data_i.opcode == OP_ALLOC) begin
            if (in_data_i.request_size == '0) begin
              res_d.status = ST_ZERO;
              state_d      = S_RESP;
            end else if (count_q == '0) begin
              state_d = S_APPEND;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            if (in_data_i.release_address == '0) begin
              state_d = S_RESP;
            end else if (count_q == '0) begin
              res_d.status = ST_UNKNOWN;
              state_d      = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // Issue the next table read while the previous entry is compared
        if (rd_idx_q < count_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_idx_q[IW-1:0];
          rd_idx_d  = rd_idx_q + CNTW'(1);
        end
        if (cmp_v_q) begin
          if (cmp_hit) begin
            flag_we    = 1'b1;
            flag_wdata = (req_q.opcode == OP_FREE);
            if (req_q.opcode == OP_ALLOC) begin
              res_d.payload_address = DATA_W'(cmp_payload);
            end
            cmp_v_d = 1'b0;
            state_d = S_RESP;
          end else if (scan_last) begin
            cmp_v_d = 1'b0;
            if (req_q.opcode == OP_ALLOC) begin
              state_d = S_APPEND;
            end else begin
              res_d.status = ST_UNKNOWN;
              state_d      = S_RESP;
            end
          end
        end
      end

      S_APPEND: begin
        wr_addr = count_q[IW-1:0];
        if ((count_q == CNTW'(MAX_BLOCKS)) || (need > NW'(limit_q))) begin
          res_d.status = ST_SPACE;
        end else begin
          tbl_we                = 1'b1;
          flag_we               = 1'b1;
          flag_wdata            = 1'b0;
          count_d               = count_q + CNTW'(1);
          used_d                = need[DATA_W-1:0];
          res_d.payload_address = DATA_W'(cmp_payload);
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      used_q      <= '0;
      rd_idx_q    <= '0;
      cmp_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      used_q      <= used_d;
      rd_idx_q    <= rd_idx_d;
      cmp_v_q     <= cmp_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    out_q     <= out_d;
    cmp_idx_q <= cmp_idx_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= HEAP_BASE_RST;
      limit_q <= HEAP_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HEAP_BASE:  base_q  <= cfg_data_i;
        CFG_HEAP_LIMIT: limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule
